// ===== rtl/hsv_pkg.sv =====
// Shared types, constants and helper functions of the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
package hsv_pkg;

	// Width of the quotient produced by the divider chain, and of every output field.
	localparam int unsigned QuotW = 15;
	// Width of a partial remainder and of a doubled 8-bit divisor.
	localparam int unsigned RemW = 9;
	// Number of divider cells: one quotient bit each.
	localparam int unsigned NumCells = QuotW;

	// Hue of one full turn, degrees times 64.
	localparam logic [QuotW-1:0] HUE_FULL_TURN = 15'd23040;
	// Twice 60 degrees times 64: numerators are doubled for round to nearest.
	localparam logic [13:0] HUE_UNIT_X2 = 14'd7680;
	// Twice 100 percent times 256.
	localparam logic [15:0] PCT_SCALE_X2 = 16'd51200;

	// Hue offsets in units of 60 degrees, chosen by the largest channel.
	localparam logic [2:0] OFF_RED = 3'd6;
	localparam logic [2:0] OFF_GREEN = 3'd2;
	localparam logic [2:0] OFF_BLUE = 3'd4;

	// One division in flight: partial remainder, pending numerator bits
	// that are replaced by quotient bits from the right, and the divisor.
	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [QuotW-1:0] nq;
		logic [RemW-1:0] den;
	} lane_t;

	// Everything one transaction carries from cell to cell.
	typedef struct packed {
		logic valid;
		lane_t hue_l;
		lane_t sat_l;
		logic grey;
		logic black;
		logic [QuotW-1:0] val;
	} cell_t;

	// Table of value in percent times 256, rounded, for each max channel.
	typedef logic [255:0][QuotW-1:0] val_tbl_t;

	function automatic val_tbl_t build_val_table();
		val_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = QuotW'((51200 * i + 255) / 510);
		end
		return t;
	endfunction

	localparam val_tbl_t VAL_TABLE = build_val_table();

	// One restoring division step: bring in the next numerator bit,
	// subtract the divisor when it fits and shift in the quotient bit.
	function automatic lane_t div_step(lane_t l);
		lane_t o;
		logic [RemW:0] t;
		logic ge;
		t = {l.rem, l.nq[QuotW-1]};
		ge = (t >= {1'b0, l.den});
		o.rem = ge ? RemW'(t - {1'b0, l.den}) : t[RemW-1:0];
		o.nq = {l.nq[QuotW-2:0], ge};
		o.den = l.den;
		return o;
	endfunction

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: input stage, divider cell chain
// and output register. Depends on hsv_pkg, hsv_front and hsv_div_cell.
//
//   channel | handshake            | payload
//   pixel   | pix_valid, pix_stall | red, green, blue (8 bits each)
//   hsv     | hsv_valid, hsv_stall | hue, saturation, brightness (15 bits each)
//
// One pixel is accepted every cycle unless hsv_stall holds a waiting result; it passes
// through the input stage, 15 divider cells (one quotient bit each)
// and the output register.
// Reset clears all valid flags; the pipeline holds no pixel after reset.
// While a result waits under hsv_stall the whole pipeline holds and pix_stall is high.
module rgb_to_hsv_converter (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	output logic hsv_valid,
	input logic hsv_stall,
	output logic [14:0] hue,
	output logic [14:0] saturation,
	output logic [14:0] brightness
);
	import hsv_pkg::*;

	logic en;
	cell_t chain [NumCells+1];
	logic [QuotW-1:0] hue_raw, hue_fix;
	logic hsv_valid_q;
	logic [QuotW-1:0] hue_q, sat_q, val_q;

	// The pipeline moves unless a finished result is held back.
	assign en = !(hsv_valid_q && hsv_stall);
	assign pix_stall = !en;

	hsv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.pix_ok(pix_valid),
		.red(red),
		.green(green),
		.blue(blue),
		.cell_s1(chain[0])
	);

	// Divider chain, one quotient bit per cell.
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		hsv_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.d(chain[i]),
			.q(chain[i+1])
		);
	end

	// Wrap a hue of a full turn or more back into range.
	always_comb begin
		hue_raw = chain[NumCells].hue_l.nq;
		hue_fix = (hue_raw >= HUE_FULL_TURN) ? hue_raw - HUE_FULL_TURN : hue_raw;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (en) begin
			hsv_valid_q <= chain[NumCells].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= chain[NumCells].grey ? '0 : hue_fix;
			sat_q <= chain[NumCells].black ? '0 : chain[NumCells].sat_l.nq;
			val_q <= chain[NumCells].val;
		end
	end

	assign hsv_valid = hsv_valid_q;
	assign hue = hue_q;
	assign saturation = sat_q;
	assign brightness = val_q;

endmodule

// ===== rtl/hsv_front.sv =====
// Input stage of the converter: max, min, difference, hue and saturation
// numerators and the value lookup, registered as stage one. Uses hsv_pkg.
module hsv_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic pix_ok,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	output hsv_pkg::cell_t cell_s1
);
	import hsv_pkg::*;

	logic [7:0] mx, mn, diff, a, c;
	logic [2:0] off;
	logic [10:0] turns;
	logic [23:0] hnum, snum;
	cell_t d;

	// Largest and smallest channel; red wins ties over green, green over blue.
	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		diff = mx - mn;
	end

	// Channel difference and hue offset by the largest channel.
	always_comb begin
		priority if (mx == red) begin
			a = green; c = blue; off = OFF_RED;
		end else if (mx == green) begin
			a = blue; c = red; off = OFF_GREEN;
		end else begin
			a = red; c = green; off = OFF_BLUE;
		end
	end

	// Doubled numerators plus half the divisor give rounding to nearest.
	always_comb begin
		turns = 11'(off) * 11'(diff) + 11'(a);
		hnum = 24'(turns) * 24'(HUE_UNIT_X2) + 24'(diff) - 24'(c) * 24'(HUE_UNIT_X2);
		snum = 24'(diff) * 24'(PCT_SCALE_X2) + 24'(mx);
		d.valid = pix_ok;
		d.hue_l.rem = hnum[23:QuotW];
		d.hue_l.nq = hnum[QuotW-1:0];
		d.hue_l.den = {diff, 1'b0};
		d.sat_l.rem = snum[23:QuotW];
		d.sat_l.nq = snum[QuotW-1:0];
		d.sat_l.den = {mx, 1'b0};
		d.grey = (diff == 8'd0);
		d.black = (mx == 8'd0);
		d.val = VAL_TABLE[mx];
	end

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= '0;
		end else if (en) begin
			cell_s1 <= d;
		end
	end

endmodule

// ===== rtl/hsv_div_cell.sv =====
// One cell of the divider chain: a single quotient bit for the hue and the
// saturation division, with the rest of the transaction passed on. Uses hsv_pkg.
module hsv_div_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input hsv_pkg::cell_t d,
	output hsv_pkg::cell_t q
);
	import hsv_pkg::*;

	cell_t nxt;

	// Both divisions advance by one bit; the side data moves along unchanged.
	always_comb begin
		nxt = d;
		nxt.hue_l = div_step(d.hue_l);
		nxt.sat_l = div_step(d.sat_l);
	end

	// Cell register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end

endmodule
